[hw/rtl/ffa_pkg.sv]
// Shared types, constants and status codes for the first-fit block allocator.
package ffa_pkg;

  // Field widths of the request, response and configuration transfers.
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned OFF_W  = 21;
  localparam int unsigned HDR_W  = 7;
  localparam int unsigned STS_W  = 3;

  // Default geometry of the pool and the block table.
  localparam int unsigned POOL_BYTES_DEF = 1024 * 1024;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  // Header size after reset.
  localparam logic [HDR_W-1:0] HEADER_RESET = HDR_W'(24);

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // One entry of the block table.
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              free;
  } blk_entry_t;

endpackage

[hw/rtl/ffa_req_if.sv]
// Request channel: allocate or free transfers into the allocator.
interface ffa_req_if;
  import ffa_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, output op, output alloc_size, output free_offset,
                  input ready);
  modport sink (input valid, input op, input alloc_size, input free_offset,
                output ready);
endinterface

[hw/rtl/ffa_rsp_if.sv]
// Response channel: one status transfer for each request.
interface ffa_rsp_if;
  import ffa_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [OFF_W-1:0] payload_offset;
  logic             was_reused;

  modport source (output valid, output status, output payload_offset,
                  output was_reused, input ready);
  modport sink (input valid, input status, input payload_offset,
                input was_reused, output ready);
endinterface

[hw/rtl/ffa_cfg_if.sv]
// Configuration write channel carrying the header size register.
interface ffa_cfg_if;
  import ffa_pkg::*;

  logic             valid;
  logic             ready;
  logic [HDR_W-1:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink (input valid, input wdata, output ready);
endinterface

[hw/rtl/first_fit_block_allocator_unit.sv]
// First-fit block allocator with a bump pointer and a table held in one memory.
//
//  Channel  Direction  Carries
//  in_if    sink       op, alloc_size, free_offset
//  out_if   source     status, payload_offset, was_reused
//  cfg_if   sink       header_bytes (always ready)
//
// One request at a time. After acceptance, the table memory is read one entry per
// cycle, pipelined against its registered read port; an allocate that finds no
// free entry then passes an extend state, and every request ends in the reply
// state. A zero-size allocate goes straight from idle to the reply state.
// Reset clears the block count and the break pointer; the table memory is
// not cleared, since only entries below the count are ever read.
// A new request is taken while a response waits in the output register; the
// reply state holds until that register is free.
module first_fit_block_allocator_unit #(
  parameter int unsigned POOL_BYTES = ffa_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ffa_req_if.sink   in_if,
  ffa_rsp_if.source out_if,
  ffa_cfg_if.sink   cfg_if
);
  import ffa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PTR_W = $clog2(POOL_BYTES + 1);
  localparam int unsigned PAY_W = PTR_W + 1;
  localparam int unsigned SUM_W = ((PAY_W > SIZE_W) ? PAY_W : SIZE_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXTEND,
    S_REPLY
  } state_t;

  // Control and datapath registers.
  state_t            state_r, state_nxt;
  logic [HDR_W-1:0]  header_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  break_r, break_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              req_op_r, req_op_nxt;
  logic [SIZE_W-1:0] req_size_r, req_size_nxt;
  logic [OFF_W-1:0]  req_off_r, req_off_nxt;
  logic [PAY_W-1:0]  payload_r, payload_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic              res_reused_r, res_reused_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic              out_reused_r, out_reused_nxt;

  // Table memory and its access signals.
  blk_entry_t        mem [MAX_BLOCKS];
  blk_entry_t        rd_data_r;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_ra;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  blk_entry_t        mem_wd;

  logic              in_xfer;
  logic              out_free;
  logic              hit;
  logic              scan_done;
  logic [SUM_W-1:0]  ext_end;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // Match test on the entry read in the previous cycle.
  always_comb begin
    if (req_op_r == OP_ALLOC) begin
      hit = chk_vld_r && rd_data_r.free && (rd_data_r.size >= req_size_r);
    end else begin
      hit = chk_vld_r && (rd_data_r.offset == req_off_r);
    end
  end

  assign scan_done = !hit && (iss_r == count_r);
  assign ext_end   = SUM_W'(payload_r) + SUM_W'(req_size_r);

  // Next-state logic for the request sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    break_nxt      = break_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    req_op_nxt     = req_op_r;
    req_size_nxt   = req_size_r;
    req_off_nxt    = req_off_r;
    payload_nxt    = payload_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_reused_nxt = res_reused_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_reused_nxt = out_reused_r;
    mem_re         = 1'b0;
    mem_ra         = iss_r[IDX_W-1:0];
    mem_we         = 1'b0;
    mem_wa         = chk_idx_r;
    mem_wd         = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_op_nxt     = in_if.op;
          req_size_nxt   = in_if.alloc_size;
          req_off_nxt    = in_if.free_offset;
          payload_nxt    = PAY_W'(break_r) + PAY_W'(header_r);
          iss_nxt        = '0;
          res_status_nxt = ST_OK;
          res_off_nxt    = '0;
          res_reused_nxt = 1'b0;
          if (in_if.op == OP_ALLOC && in_if.alloc_size == '0) begin
            res_status_nxt = ST_ZERO;
            state_nxt      = S_REPLY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // Mark the matching entry taken (allocate) or free (free) and write it back.
          mem_we = 1'b1;
          mem_wa = chk_idx_r;
          if (req_op_r == OP_ALLOC) begin
            mem_wd.free    = 1'b0;
            res_off_nxt    = rd_data_r.offset;
            res_reused_nxt = 1'b1;
          end else begin
            mem_wd.free = 1'b1;
          end
          state_nxt = S_REPLY;
        end else if (scan_done) begin
          if (req_op_r == OP_ALLOC) begin
            state_nxt = S_EXTEND;
          end else begin
            if (req_off_r != '0) begin
              res_status_nxt = ST_UNKNOWN;
            end
            state_nxt = S_REPLY;
          end
        end else begin
          // Issue the next table read; its data is checked next cycle.
          mem_re      = 1'b1;
          mem_ra      = iss_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + CNT_W'(1);
        end
      end

      S_EXTEND: begin
        // Carve a new block at the break when the pool and the table allow.
        if (ext_end > SUM_W'(POOL_BYTES)) begin
          res_status_nxt = ST_OOM;
        end else if (count_r == CNT_W'(MAX_BLOCKS)) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we         = 1'b1;
          mem_wa         = count_r[IDX_W-1:0];
          mem_wd.offset  = OFF_W'(payload_r);
          mem_wd.size    = req_size_r;
          mem_wd.free    = 1'b0;
          count_nxt      = count_r + CNT_W'(1);
          break_nxt      = ext_end[PTR_W-1:0];
          res_off_nxt    = OFF_W'(payload_r);
        end
        state_nxt = S_REPLY;
      end

      S_REPLY: begin
        // Load the response once the output register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_reused_nxt = res_reused_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      header_r    <= HEADER_RESET;
      count_r     <= '0;
      break_r     <= '0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      break_r     <= break_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        header_r <= cfg_if.wdata;
      end
    end
    chk_idx_r    <= chk_idx_nxt;
    req_op_r     <= req_op_nxt;
    req_size_r   <= req_size_nxt;
    req_off_r    <= req_off_nxt;
    payload_r    <= payload_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_reused_r <= res_reused_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_reused_r <= out_reused_nxt;
  end

  // Block table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Port drive.
  assign in_if.ready           = (state_r == S_IDLE);
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.payload_offset = out_off_r;
  assign out_if.was_reused     = out_reused_r;

  // The block count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  // The break pointer stays inside the pool.
  a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
    break_r <= PTR_W'(POOL_BYTES))
    else $error("break pointer beyond pool");

  // Table writes only touch live entries or the next free slot.
  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CNT_W'(mem_wa) <= count_r))
    else $error("table write beyond block count");

  // A pending read check exists only during the table scan.
  a_check_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_SCAN))
    else $error("read check outside scan");

  // A new block grows the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXTEND && mem_we) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("count did not advance after extend");

endmodule
